@@ rtl/core/mocc_pkg.sv @@
`timescale 1ns / 1ps
// Package: widths, register indexes and shared types for the magnetometer correction block.
package mocc_pkg;

    localparam int NUM_AXES   = 3;
    localparam int NUM_MOTORS = 4;

    localparam int RAW_W    = 16;                    // raw axis word, offset, coefficient
    localparam int CUR_W    = 16;                    // motor current count
    localparam int SCALE_W  = 25;                    // unsigned Q1.24 scale
    localparam int DIFF_W   = RAW_W + 1;             // raw minus offset
    localparam int BASE_W   = DIFF_W + SCALE_W + 1;  // signed diff times unsigned scale
    localparam int CPROD_W  = RAW_W + CUR_W + 1;     // coefficient times current
    localparam int CSUM_W   = CPROD_W + 2;           // sum over four motors
    localparam int SCALE_SH = 4;                     // 2^-24 units to 2^-28 units
    localparam int TOT_W    = 48;                    // total in 2^-28 units
    localparam int FRAC_SH  = 12;                    // 2^-28 to Q3.16
    localparam int Q_W      = TOT_W - FRAC_SH;
    localparam int FIELD_W  = 20;
    localparam int CFG_W    = 64;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [TOT_W-1:0]   ROUND_HALF = TOT_W'(1 << (FRAC_SH - 1));
    localparam logic signed [FIELD_W-1:0] FIELD_MAX  = 20'sh7FFFF;
    localparam logic signed [FIELD_W-1:0] FIELD_MIN  = 20'sh80000;

    localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(1 << 24);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSETS = 3'd0,
        CFG_SCALE_X = 3'd1,
        CFG_SCALE_Y = 3'd2,
        CFG_SCALE_Z = 3'd3,
        CFG_COEF_X  = 3'd4,
        CFG_COEF_Y  = 3'd5,
        CFG_COEF_Z  = 3'd6,
        CFG_COMP_EN = 3'd7
    } t_cfg_idx;

    // load enables of the four pipeline stages
    typedef struct packed {
        logic diff;   // stage 1: offset subtract, current gating
        logic mult;   // stage 2: products
        logic part;   // stage 3: base shift, motor sum
        logic fin;    // stage 4: combine, round, saturate
    } t_stage_en;

    typedef struct packed {
        logic signed [BASE_W-1:0]            base;
        logic [NUM_MOTORS-1:0][CPROD_W-1:0]  comp;
    } t_lane_prod;

endpackage

@@ rtl/core/mocc_lane.sv @@
`timescale 1ns / 1ps
// One axis lane: offset subtract, scale product and four motor coefficient products.
module mocc_lane (
    input  logic                                           i_clk,
    input  mocc_pkg::t_stage_en                            i_en,
    input  logic signed [mocc_pkg::RAW_W-1:0]              i_raw,
    input  logic signed [mocc_pkg::RAW_W-1:0]              i_off,
    input  logic [mocc_pkg::SCALE_W-1:0]                   i_scale,
    input  logic [mocc_pkg::NUM_MOTORS*mocc_pkg::RAW_W-1:0] i_coef,
    input  logic [mocc_pkg::NUM_MOTORS-1:0][mocc_pkg::CUR_W-1:0] i_cur,
    input  logic                                           i_comp_on,
    output mocc_pkg::t_lane_prod                           o_prod
);

    logic signed [mocc_pkg::DIFF_W-1:0]                     r_diff;
    logic [mocc_pkg::NUM_MOTORS-1:0][mocc_pkg::CUR_W-1:0]  r_cur;
    logic signed [mocc_pkg::DIFF_W-1:0]                     n_diff;
    mocc_pkg::t_lane_prod                                   n_prod;
    mocc_pkg::t_lane_prod                                   r_prod;

    assign n_diff = {i_raw[mocc_pkg::RAW_W-1], i_raw} - {i_off[mocc_pkg::RAW_W-1], i_off};

    always_ff @(posedge i_clk) begin
        if (i_en.diff) begin
            r_diff <= n_diff;
            // currents forced to zero when compensation is off
            r_cur  <= i_comp_on ? i_cur : '0;
        end
    end

    always_comb begin
        n_prod.base = mocc_pkg::BASE_W'(r_diff)
                    * mocc_pkg::BASE_W'($signed({1'b0, i_scale}));
        for (int m = 0; m < mocc_pkg::NUM_MOTORS; m++) begin
            n_prod.comp[m] =
                mocc_pkg::CPROD_W'($signed(i_coef[m*mocc_pkg::RAW_W +: mocc_pkg::RAW_W]))
                * mocc_pkg::CPROD_W'($signed({1'b0, r_cur[m]}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.mult) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

@@ rtl/core/mocc_merge.sv @@
`timescale 1ns / 1ps
// Merge stage: joins scale and motor terms of each lane, rounds and saturates to Q3.16.
module mocc_merge (
    input  logic                                    i_clk,
    input  mocc_pkg::t_stage_en                     i_en,
    input  mocc_pkg::t_lane_prod                    i_prod  [mocc_pkg::NUM_AXES],
    output logic signed [mocc_pkg::FIELD_W-1:0]     o_field [mocc_pkg::NUM_AXES]
);

    logic signed [mocc_pkg::TOT_W-1:0]   r_base [mocc_pkg::NUM_AXES];
    logic signed [mocc_pkg::CSUM_W-1:0]  r_csum [mocc_pkg::NUM_AXES];
    logic signed [mocc_pkg::FIELD_W-1:0] r_field [mocc_pkg::NUM_AXES];
    logic signed [mocc_pkg::TOT_W-1:0]   n_base [mocc_pkg::NUM_AXES];
    logic signed [mocc_pkg::CSUM_W-1:0]  n_csum [mocc_pkg::NUM_AXES];
    logic signed [mocc_pkg::FIELD_W-1:0] n_field [mocc_pkg::NUM_AXES];
    logic signed [mocc_pkg::TOT_W-1:0]   ext_base [mocc_pkg::NUM_AXES];
    logic signed [mocc_pkg::TOT_W-1:0]   total [mocc_pkg::NUM_AXES];
    logic signed [mocc_pkg::Q_W-1:0]     quot [mocc_pkg::NUM_AXES];

    // stage 3: negate and align the scale term (rounding bias folded in), sum motor terms
    always_comb begin
        for (int a = 0; a < mocc_pkg::NUM_AXES; a++) begin
            ext_base[a] = mocc_pkg::TOT_W'(i_prod[a].base);
            n_base[a]   = ((-ext_base[a]) <<< mocc_pkg::SCALE_SH) + mocc_pkg::ROUND_HALF;
            n_csum[a]   = '0;
            for (int m = 0; m < mocc_pkg::NUM_MOTORS; m++) begin
                n_csum[a] = n_csum[a]
                          + mocc_pkg::CSUM_W'($signed(i_prod[a].comp[m]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.part) begin
            r_base <= n_base;
            r_csum <= n_csum;
        end
    end

    // stage 4: subtract, floor shift, clamp
    always_comb begin
        for (int a = 0; a < mocc_pkg::NUM_AXES; a++) begin
            total[a] = r_base[a] - mocc_pkg::TOT_W'(r_csum[a]);
            quot[a]  = total[a][mocc_pkg::TOT_W-1:mocc_pkg::FRAC_SH];
            priority if (quot[a] > mocc_pkg::Q_W'(mocc_pkg::FIELD_MAX)) begin
                n_field[a] = mocc_pkg::FIELD_MAX;
            end else if (quot[a] < mocc_pkg::Q_W'(mocc_pkg::FIELD_MIN)) begin
                n_field[a] = mocc_pkg::FIELD_MIN;
            end else begin
                n_field[a] = quot[a][mocc_pkg::FIELD_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.fin) begin
            r_field <= n_field;
        end
    end

    assign o_field = r_field;

endmodule

@@ rtl/core/magnetometer_offset_current_correction.sv @@
`timescale 1ns / 1ps
// Top level: magnetometer hard-iron offset, scale and motor-current compensation pipeline.
// Stages diff, multiply, partial sum and final are registered; a stage loads when empty or
// its successor loads. Throughput: one beat per cycle while the sink is ready.
// Reset (i_rst_n low, synchronous): pipeline emptied, offsets and coefficients zero,
// scales 1.0, compensation enabled. No clearing pass; input ready once reset is released.
module magnetometer_offset_current_correction (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration writes
    input  logic                                   i_cfg_we,
    input  logic [mocc_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [mocc_pkg::CFG_W-1:0]             i_cfg_data,
    // input channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic signed [mocc_pkg::RAW_W-1:0]      i_raw_x,
    input  logic signed [mocc_pkg::RAW_W-1:0]      i_raw_y,
    input  logic signed [mocc_pkg::RAW_W-1:0]      i_raw_z,
    input  logic [mocc_pkg::CUR_W-1:0]             i_motor_current_0,
    input  logic [mocc_pkg::CUR_W-1:0]             i_motor_current_1,
    input  logic [mocc_pkg::CUR_W-1:0]             i_motor_current_2,
    input  logic [mocc_pkg::CUR_W-1:0]             i_motor_current_3,
    input  logic                                   i_motors_running,
    // output channel
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [mocc_pkg::FIELD_W-1:0]    o_field_x,
    output logic signed [mocc_pkg::FIELD_W-1:0]    o_field_y,
    output logic signed [mocc_pkg::FIELD_W-1:0]    o_field_z
);

    // ---------------- configuration registers ----------------
    logic [3*mocc_pkg::RAW_W-1:0]                  r_offsets;
    logic [mocc_pkg::SCALE_W-1:0]                  r_scale_x, r_scale_y, r_scale_z;
    logic [mocc_pkg::CFG_W-1:0]                    r_coef_x, r_coef_y, r_coef_z;
    logic                                          r_comp_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offsets <= '0;
            r_scale_x <= mocc_pkg::SCALE_ONE;
            r_scale_y <= mocc_pkg::SCALE_ONE;
            r_scale_z <= mocc_pkg::SCALE_ONE;
            r_coef_x  <= '0;
            r_coef_y  <= '0;
            r_coef_z  <= '0;
            r_comp_en <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (mocc_pkg::t_cfg_idx'(i_cfg_idx))
                mocc_pkg::CFG_OFFSETS: r_offsets <= i_cfg_data[3*mocc_pkg::RAW_W-1:0];
                mocc_pkg::CFG_SCALE_X: r_scale_x <= i_cfg_data[mocc_pkg::SCALE_W-1:0];
                mocc_pkg::CFG_SCALE_Y: r_scale_y <= i_cfg_data[mocc_pkg::SCALE_W-1:0];
                mocc_pkg::CFG_SCALE_Z: r_scale_z <= i_cfg_data[mocc_pkg::SCALE_W-1:0];
                mocc_pkg::CFG_COEF_X:  r_coef_x  <= i_cfg_data;
                mocc_pkg::CFG_COEF_Y:  r_coef_y  <= i_cfg_data;
                mocc_pkg::CFG_COEF_Z:  r_coef_z  <= i_cfg_data;
                mocc_pkg::CFG_COMP_EN: r_comp_en <= i_cfg_data[0];
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    // r_vld[k] marks a beat held in stage k+1. A stage loads when it is empty or
    // its successor loads, so bubbles collapse and input keeps flowing while the
    // output register waits, until every stage holds a beat.
    logic [3:0]            r_vld;
    logic [3:0]            adv;
    mocc_pkg::t_stage_en   st_en;

    assign adv[3] = !r_vld[3] || i_out_ready;
    assign adv[2] = !r_vld[2] || adv[3];
    assign adv[1] = !r_vld[1] || adv[2];
    assign adv[0] = !r_vld[0] || adv[1];

    assign st_en.diff = adv[0];
    assign st_en.mult = adv[1];
    assign st_en.part = adv[2];
    assign st_en.fin  = adv[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) r_vld[0] <= i_in_valid;
            if (adv[1]) r_vld[1] <= r_vld[0];
            if (adv[2]) r_vld[2] <= r_vld[1];
            if (adv[3]) r_vld[3] <= r_vld[2];
        end
    end

    assign o_in_ready  = adv[0];
    assign o_out_valid = r_vld[3];

    // ---------------- lanes ----------------
    // Axis swap: output x is built from raw y, output y from raw x.
    logic                                                    comp_on;
    logic [mocc_pkg::NUM_MOTORS-1:0][mocc_pkg::CUR_W-1:0]   cur;
    mocc_pkg::t_lane_prod                                    prod [mocc_pkg::NUM_AXES];
    logic signed [mocc_pkg::FIELD_W-1:0]                     field [mocc_pkg::NUM_AXES];

    assign comp_on = i_motors_running && r_comp_en;
    assign cur[0]  = i_motor_current_0;
    assign cur[1]  = i_motor_current_1;
    assign cur[2]  = i_motor_current_2;
    assign cur[3]  = i_motor_current_3;

    mocc_lane u_lane_x (
        .i_clk     (i_clk),
        .i_en      (st_en),
        .i_raw     (i_raw_y),
        .i_off     ($signed(r_offsets[2*mocc_pkg::RAW_W-1:mocc_pkg::RAW_W])),
        .i_scale   (r_scale_y),
        .i_coef    (r_coef_x),
        .i_cur     (cur),
        .i_comp_on (comp_on),
        .o_prod    (prod[0])
    );

    mocc_lane u_lane_y (
        .i_clk     (i_clk),
        .i_en      (st_en),
        .i_raw     (i_raw_x),
        .i_off     ($signed(r_offsets[mocc_pkg::RAW_W-1:0])),
        .i_scale   (r_scale_x),
        .i_coef    (r_coef_y),
        .i_cur     (cur),
        .i_comp_on (comp_on),
        .o_prod    (prod[1])
    );

    mocc_lane u_lane_z (
        .i_clk     (i_clk),
        .i_en      (st_en),
        .i_raw     (i_raw_z),
        .i_off     ($signed(r_offsets[3*mocc_pkg::RAW_W-1:2*mocc_pkg::RAW_W])),
        .i_scale   (r_scale_z),
        .i_coef    (r_coef_z),
        .i_cur     (cur),
        .i_comp_on (comp_on),
        .o_prod    (prod[2])
    );

    // ---------------- merge, round, saturate ----------------
    mocc_merge u_merge (
        .i_clk   (i_clk),
        .i_en    (st_en),
        .i_prod  (prod),
        .o_field (field)
    );

    assign o_field_x = field[0];
    assign o_field_y = field[1];
    assign o_field_z = field[2];

    // ---------------- assertions ----------------
    // full pipeline with a stalled output must refuse new beats
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld == 4'hF && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted into a full stalled pipeline");

    // an accepted beat reaches the output when the sink keeps up
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready
        |=> o_out_valid)
        else $error("beat did not reach output in four cycles");

    // a beat in stage 3 is never lost while downstream is stalled
    a_mid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[2] && !adv[3]) |=> r_vld[2])
        else $error("stage 3 beat dropped during stall");

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// Testbench: randomized valid/ready check of the magnetometer correction pipeline.
module tb;
    import mocc_pkg::*;

    localparam int LIMIT_CYCLES  = 200000;
    localparam int DRAIN_CYCLES  = 8;       // pipeline is 4 deep
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 70;

    // one input beat
    typedef struct packed {
        logic signed [RAW_W-1:0]          raw_x;
        logic signed [RAW_W-1:0]          raw_y;
        logic signed [RAW_W-1:0]          raw_z;
        logic [NUM_MOTORS-1:0][CUR_W-1:0] current;
        logic                             running;
    } t_sample;

    // one output beat, index 0 = field_x, 1 = field_y, 2 = field_z
    typedef logic [NUM_AXES-1:0][FIELD_W-1:0] t_fields;

    // ---------------------------------------------------------------
    // DUT signals, all inputs known from time zero
    // ---------------------------------------------------------------
    logic                       i_clk             = 1'b0;
    logic                       i_rst_n           = 1'b0;
    logic                       i_cfg_we          = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_idx         = '0;
    logic [CFG_W-1:0]           i_cfg_data        = '0;
    logic                       i_in_valid        = 1'b0;
    logic                       o_in_ready;
    logic signed [RAW_W-1:0]    i_raw_x           = '0;
    logic signed [RAW_W-1:0]    i_raw_y           = '0;
    logic signed [RAW_W-1:0]    i_raw_z           = '0;
    logic [CUR_W-1:0]           i_motor_current_0 = '0;
    logic [CUR_W-1:0]           i_motor_current_1 = '0;
    logic [CUR_W-1:0]           i_motor_current_2 = '0;
    logic [CUR_W-1:0]           i_motor_current_3 = '0;
    logic                       i_motors_running  = 1'b0;
    logic                       o_out_valid;
    logic                       i_out_ready       = 1'b0;
    logic signed [FIELD_W-1:0]  o_field_x;
    logic signed [FIELD_W-1:0]  o_field_y;
    logic signed [FIELD_W-1:0]  o_field_z;

    // ---------------------------------------------------------------
    // Shadow copy of the register file (reset values)
    // ---------------------------------------------------------------
    logic [47:0]        cfg_offsets = '0;
    logic [SCALE_W-1:0] cfg_scale_x = SCALE_ONE;
    logic [SCALE_W-1:0] cfg_scale_y = SCALE_ONE;
    logic [SCALE_W-1:0] cfg_scale_z = SCALE_ONE;
    logic [63:0]        cfg_coef_x  = '0;
    logic [63:0]        cfg_coef_y  = '0;
    logic [63:0]        cfg_coef_z  = '0;
    logic               cfg_comp_en = 1'b1;

    // ---------------------------------------------------------------
    // Stimulus / scoreboard storage and driver/monitor state
    // ---------------------------------------------------------------
    t_sample pending_samples[$];    // filled by the sequence, drained by the driver
    t_fields expected_fields[$];    // pushed on input beat, popped on output beat
    t_sample in_sample;
    bit      in_holding  = 1'b0;    // driver is presenting a beat
    int      in_gap      = 0;
    int      in_calm     = 0;       // beats left in a no-idle stretch
    int      out_stall   = 0;
    int      out_calm    = 0;
    int      error_count = 0;
    int      cycle_count = 0;

    magnetometer_offset_current_correction DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_raw_x           (i_raw_x),
        .i_raw_y           (i_raw_y),
        .i_raw_z           (i_raw_z),
        .i_motor_current_0 (i_motor_current_0),
        .i_motor_current_1 (i_motor_current_1),
        .i_motor_current_2 (i_motor_current_2),
        .i_motor_current_3 (i_motor_current_3),
        .i_motors_running  (i_motors_running),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_field_x         (o_field_x),
        .o_field_y         (o_field_y),
        .o_field_z         (o_field_z)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Predictor. All work in 2^-28 units, exact in 64 bits.
    // ---------------------------------------------------------------

    // -(raw - offset) * scale, scale is Q1.24 so shift by 4 more
    function automatic longint axis_base(logic signed [RAW_W-1:0] raw,
                                         logic signed [RAW_W-1:0] off,
                                         logic [SCALE_W-1:0] scale);
        longint diff;
        longint s;
        diff = raw - off;
        s    = scale;
        return -(diff * s) * 16;
    endfunction

    // sum over motors of signed coefficient times unsigned current
    function automatic longint motor_pull(logic [63:0] coefs, t_sample smp);
        longint sum;
        longint c;
        longint k;
        int     m;
        sum = 0;
        for (m = 0; m < NUM_MOTORS; m++) begin
            c   = $signed(coefs[16*m +: 16]);
            k   = smp.current[m];
            sum += c * k;
        end
        return sum;
    endfunction

    // round half toward +inf into Q3.16, then clamp
    function automatic logic [FIELD_W-1:0] round_saturate(longint total);
        longint q;
        q = (total + ROUND_HALF) >>> FRAC_SH;
        if (q > FIELD_MAX)
            q = FIELD_MAX;
        if (q < FIELD_MIN)
            q = FIELD_MIN;
        return q[FIELD_W-1:0];
    endfunction

    // axes are swapped: field_x from raw_y, field_y from raw_x
    function automatic t_fields correct_sample(t_sample smp);
        longint  fx;
        longint  fy;
        longint  fz;
        t_fields f;
        fx = axis_base(smp.raw_y, cfg_offsets[31:16], cfg_scale_y);
        fy = axis_base(smp.raw_x, cfg_offsets[15:0],  cfg_scale_x);
        fz = axis_base(smp.raw_z, cfg_offsets[47:32], cfg_scale_z);
        if (smp.running && cfg_comp_en) begin
            fx -= motor_pull(cfg_coef_x, smp);
            fy -= motor_pull(cfg_coef_y, smp);
            fz -= motor_pull(cfg_coef_z, smp);
        end
        f[0] = round_saturate(fx);
        f[1] = round_saturate(fy);
        f[2] = round_saturate(fz);
        return f;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // 16-bit word biased toward the corners
    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return 16'($urandom());
        endcase
    endfunction

    // zero, one, max, near one, or spread over many octaves
    function automatic logic [SCALE_W-1:0] pick_scale();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return SCALE_ONE;
            2: return '1;
            3: return SCALE_ONE + SCALE_W'($urandom_range(0, 65535)) - SCALE_W'(32768);
            default: return SCALE_W'($urandom_range(0, 33554431) >> $urandom_range(0, 16));
        endcase
    endfunction

    // raw word: mostly near the hard-iron offset so results do not all clip
    function automatic logic [15:0] near_axis(logic [15:0] off);
        int span;
        int d;
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom());
        span = 1 << $urandom_range(0, 11);
        d    = $urandom_range(0, 2 * span) - span;
        return off + 16'(d);
    endfunction

    function automatic t_sample random_sample();
        t_sample smp;
        int      m;
        smp.raw_x = near_axis(cfg_offsets[15:0]);
        smp.raw_y = near_axis(cfg_offsets[31:16]);
        smp.raw_z = near_axis(cfg_offsets[47:32]);
        for (m = 0; m < NUM_MOTORS; m++) begin
            case ($urandom_range(0, 7))
                0: smp.current[m] = '0;
                1: smp.current[m] = '1;
                default: smp.current[m] = 16'($urandom_range(0, 65535) >> $urandom_range(0, 8));
            endcase
        end
        smp.running = ($urandom_range(0, 3) != 0);
        return smp;
    endfunction

    function automatic t_sample make_sample(int rx, int ry, int rz, logic [63:0] cur,
                                            logic run);
        t_sample smp;
        smp.raw_x   = rx[15:0];
        smp.raw_y   = ry[15:0];
        smp.raw_z   = rz[15:0];
        smp.current = cur;
        smp.running = run;
        return smp;
    endfunction

    // Register write; the shadow copy follows with the same masking as the block.
    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_OFFSETS: cfg_offsets = value[47:0];
            CFG_SCALE_X: cfg_scale_x = value[SCALE_W-1:0];
            CFG_SCALE_Y: cfg_scale_y = value[SCALE_W-1:0];
            CFG_SCALE_Z: cfg_scale_z = value[SCALE_W-1:0];
            CFG_COEF_X:  cfg_coef_x  = value;
            CFG_COEF_Y:  cfg_coef_y  = value;
            CFG_COEF_Z:  cfg_coef_z  = value;
            CFG_COMP_EN: cfg_comp_en = value[0];
            default: ;
        endcase
    endtask

    // Every register once, unused upper data bits filled with noise.
    task automatic randomize_settings();
        logic [CFG_W-1:0] d;
        d = rand64();
        d[47:0] = {pick_word(), pick_word(), pick_word()};
        write_reg(CFG_OFFSETS, d);
        d = rand64();
        d[SCALE_W-1:0] = pick_scale();
        write_reg(CFG_SCALE_X, d);
        d = rand64();
        d[SCALE_W-1:0] = pick_scale();
        write_reg(CFG_SCALE_Y, d);
        d = rand64();
        d[SCALE_W-1:0] = pick_scale();
        write_reg(CFG_SCALE_Z, d);
        write_reg(CFG_COEF_X, {pick_word(), pick_word(), pick_word(), pick_word()});
        write_reg(CFG_COEF_Y, {pick_word(), pick_word(), pick_word(), pick_word()});
        write_reg(CFG_COEF_Z, {pick_word(), pick_word(), pick_word(), pick_word()});
        d = rand64();
        d[0] = ($urandom_range(0, 3) != 0);
        write_reg(CFG_COMP_EN, d);
    endtask

    // Block is idle once every queued beat went in and every result came out.
    task automatic wait_drained();
        while (pending_samples.size() != 0 || in_holding || expected_fields.size() != 0)
            @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial begin
        int p;
        int n;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: scale 1.0, no offsets, coefficients zero
        pending_samples.push_back(make_sample(0, 0, 0, 64'h0, 1'b0));
        pending_samples.push_back(make_sample(32767, -32768, 7, 64'h0, 1'b0));
        pending_samples.push_back(make_sample(-32768, 32767, -8, '1, 1'b1));
        pending_samples.push_back(make_sample(1, -1, -7, 64'hffff_0000_ffff_0000, 1'b1));
        wait_drained();

        // extremes: x and y offsets at the corners, x scale above one (full 25 bits),
        // y scale 2^-17 so odd diffs land exactly on a rounding tie, z scale zero
        write_reg(CFG_OFFSETS, 64'ha5a5_0001_7fff_8000);
        write_reg(CFG_SCALE_X, 64'hffff_ffff_ffff_ffff);
        write_reg(CFG_SCALE_Y, 64'h0000_0000_0000_0080);
        write_reg(CFG_SCALE_Z, 64'hffff_ffff_fe00_0000);
        write_reg(CFG_COEF_X,  64'h7fff_7fff_7fff_7fff);
        write_reg(CFG_COEF_Y,  64'h8000_8000_8000_8000);
        write_reg(CFG_COEF_Z,  64'h8000_7fff_0001_ffff);
        write_reg(CFG_COMP_EN, 64'h0000_0000_0000_0001);
        pending_samples.push_back(make_sample(32767, 32766, 5, 64'h0, 1'b1));
        pending_samples.push_back(make_sample(-32768, -32768, -32768, '1, 1'b1));
        pending_samples.push_back(make_sample(0, 0, 0, '1, 1'b0));
        pending_samples.push_back(make_sample(-1, 32767, 1, 64'h0001_0001_0001_0001, 1'b1));
        pending_samples.push_back(make_sample(12345, -2, -32768, 64'hffff_0000_8000_0001,
                                              1'b1));
        pending_samples.push_back(make_sample(32767, 32767, 32767, 64'h0000_ffff_0000_ffff,
                                              1'b1));
        pending_samples.push_back(make_sample(-32767, -32767, 0, '1, 1'b0));
        wait_drained();

        // compensation disabled while motors run
        write_reg(CFG_COMP_EN, 64'hffff_ffff_ffff_fffe);
        pending_samples.push_back(make_sample(100, 32766, 3, '1, 1'b1));
        pending_samples.push_back(make_sample(-100, 32765, -3, 64'h1234_5678_9abc_def0, 1'b1));
        pending_samples.push_back(make_sample(0, 0, 0, '1, 1'b1));
        wait_drained();

        // random settings, random beats
        for (p = 0; p < RANDOM_PHASES; p++) begin
            randomize_settings();
            for (n = 0; n < PHASE_ITEMS; n++)
                pending_samples.push_back(random_sample());
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("magnetometer_offset_current_correction verification clean");
        else
            $display("magnetometer_offset_current_correction verification failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // Input driver: one beat at a time, random gap before each,
    // with occasional back-to-back stretches
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_holding = 1'b0;
            in_gap     = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                // beat taken: predict now, against the settings in force
                expected_fields.push_back(correct_sample(in_sample));
                in_holding = 1'b0;
                if (in_calm > 0) begin
                    in_calm--;
                    in_gap = 0;
                end else begin
                    in_gap = $urandom_range(0, 19);
                    if ($urandom_range(0, 15) == 0)
                        in_calm = $urandom_range(8, 40);
                end
            end
            if (!in_holding) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (pending_samples.size() != 0) begin
                    in_sample = pending_samples.pop_front();
                    i_raw_x           <= in_sample.raw_x;
                    i_raw_y           <= in_sample.raw_y;
                    i_raw_z           <= in_sample.raw_z;
                    i_motor_current_0 <= in_sample.current[0];
                    i_motor_current_1 <= in_sample.current[1];
                    i_motor_current_2 <= in_sample.current[2];
                    i_motor_current_3 <= in_sample.current[3];
                    i_motors_running  <= in_sample.running;
                    in_holding = 1'b1;
                end
            end
            // single update per edge; stays high across back-to-back beats
            i_in_valid <= in_holding;
        end
    end

    // ---------------------------------------------------------------
    // Output monitor: checks each beat, then may stall ready at random
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_fields got;
        t_fields want;
        int      m;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_stall = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                got = {o_field_z, o_field_y, o_field_x};
                if (expected_fields.size() == 0) begin
                    $display("%0t: unexpected beat x=%0d y=%0d z=%0d", $time,
                             o_field_x, o_field_y, o_field_z);
                    error_count++;
                end else begin
                    want = expected_fields.pop_front();
                    for (m = 0; m < NUM_AXES; m++) begin
                        if (got[m] !== want[m]) begin
                            $display("%0t: field_%s expected %0d actual %0d", $time,
                                     (m == 0) ? "x" : (m == 1) ? "y" : "z",
                                     $signed(want[m]), $signed(got[m]));
                            error_count++;
                        end
                    end
                end
                if (out_calm > 0) begin
                    out_calm--;
                    out_stall = 0;
                end else begin
                    out_stall = $urandom_range(0, 19);
                    if ($urandom_range(0, 15) == 0)
                        out_calm = $urandom_range(8, 40);
                end
            end else if (out_stall > 0) begin
                out_stall--;
            end
            i_out_ready <= (out_stall == 0);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("%0t: timeout, %0d results outstanding", $time, expected_fields.size());
            $display("magnetometer_offset_current_correction verification failed");
            $finish;
        end
    end

endmodule
